// File: rtl/core/ttc_pkg.sv
`timescale 1ns / 1ps

package ttc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_TEX   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 18;
    localparam int INDEX_W   = 24;
    localparam int WEIGHT_W  = 20;
    localparam int CELL_W    = 12;

    // sample coordinate divide: quotient bits and divisor (2 * dim) bits
    localparam int SQ_W      = 21;
    localparam int SD_W      = 14;
    // bias added to the sample quotient so the restoring divider sees only positive values
    localparam int SAMPLE_BIAS_SH = 18;
    localparam int PX_W      = 21;

    // weight divide: quotient bits and divisor (|det|) bits
    localparam int WQ_W      = 20;
    localparam int WD_W      = 38;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_OFFSET_X = 2'd2,
        CFG_OFFSET_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] au;
        logic signed [COORD_W-1:0] av;
        logic signed [COORD_W-1:0] bu;
        logic signed [COORD_W-1:0] bv;
        logic signed [COORD_W-1:0] cu;
        logic signed [COORD_W-1:0] cv;
    } corners_t;

    typedef struct packed {
        corners_t corners;
        logic     sat_x;
        logic     sat_y;
    } samp_side_t;

    typedef struct packed {
        logic degenerate;
        logic covered;
        logic a_max;
        logic a_min;
        logic b_max;
        logic b_min;
    } wflags_t;

endpackage

// File: rtl/core/ttc_div.sv
`timescale 1ns / 1ps

module ttc_div #(
    parameter int Q_W    = 24,
    parameter int D_W    = 13,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [LANES-1:0][D_W-1:0]     s_num_hi,
    input  logic [LANES-1:0][Q_W-1:0]     s_num_lo,
    input  logic [LANES-1:0][D_W-1:0]     s_den,
    input  logic [SIDE_W-1:0]             s_side,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [LANES-1:0][Q_W-1:0]     m_quot,
    output logic [LANES-1:0][D_W-1:0]     m_rem,
    output logic [SIDE_W-1:0]             m_side
);
    // One quotient bit per stage; s_num_hi must be below s_den.

    logic [Q_W-1:0]                  vld_reg;
    logic [Q_W-1:0]                  vld_src;
    logic [Q_W:0]                    rdy;
    logic [LANES-1:0][D_W-1:0]       rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]       lo_reg   [Q_W];
    logic [LANES-1:0][D_W-1:0]       den_reg  [Q_W];
    logic [SIDE_W-1:0]               side_reg [Q_W];
    logic [LANES-1:0][D_W-1:0]       rem_src  [Q_W];
    logic [LANES-1:0][Q_W-1:0]       lo_src   [Q_W];
    logic [LANES-1:0][D_W-1:0]       den_src  [Q_W];
    logic [SIDE_W-1:0]               side_src [Q_W];
    logic [LANES-1:0][D_W-1:0]       rem_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]       lo_next  [Q_W];

    always_comb begin
        vld_src[0]  = s_valid;
        rem_src[0]  = s_num_hi;
        lo_src[0]   = s_num_lo;
        den_src[0]  = s_den;
        side_src[0] = s_side;
        for (int k = 1; k < Q_W; k++) begin
            vld_src[k]  = vld_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            lo_src[k]   = lo_reg[k-1];
            den_src[k]  = den_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    always_comb begin
        logic [D_W:0] shifted;
        logic [D_W:0] trial;
        shifted = '0;
        trial   = '0;
        for (int k = 0; k < Q_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                shifted = {rem_src[k][l], lo_src[k][l][Q_W-1]};
                trial   = shifted - {1'b0, den_src[k][l]};
                if (trial[D_W]) begin
                    rem_next[k][l] = shifted[D_W-1:0];
                    lo_next[k][l]  = {lo_src[k][l][Q_W-2:0], 1'b0};
                end else begin
                    rem_next[k][l] = trial[D_W-1:0];
                    lo_next[k][l]  = {lo_src[k][l][Q_W-2:0], 1'b1};
                end
            end
        end
    end

    // a stage takes a new item when it is empty or its item moves on
    always_comb begin
        rdy[Q_W] = m_ready;
        for (int k = Q_W - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < Q_W; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (rdy[k] && vld_src[k]) begin
                rem_reg[k]  <= rem_next[k];
                lo_reg[k]   <= lo_next[k];
                den_reg[k]  <= den_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[Q_W-1];
    assign m_quot  = lo_reg[Q_W-1];
    assign m_rem   = rem_reg[Q_W-1];
    assign m_side  = side_reg[Q_W-1];

endmodule

// File: rtl/core/ttc_sample.sv
`timescale 1ns / 1ps

module ttc_sample (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ttc_pkg::INDEX_W-1:0]           s_row,
    input  logic [ttc_pkg::CELL_W-1:0]            s_col,
    input  ttc_pkg::corners_t                     s_corners,
    input  logic [ttc_pkg::DIM_W-1:0]             dim_w,
    input  logic [ttc_pkg::DIM_W-1:0]             dim_h,
    input  logic signed [ttc_pkg::COORD_W-1:0]    offset_x,
    input  logic signed [ttc_pkg::COORD_W-1:0]    offset_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0][ttc_pkg::SD_W-1:0]         m_num_hi,
    output logic [1:0][ttc_pkg::SQ_W-1:0]         m_num_lo,
    output logic [1:0][ttc_pkg::SD_W-1:0]         m_den,
    output ttc_pkg::samp_side_t                   m_side
);
    import ttc_pkg::*;

    localparam int NUM_W = 45;

    // 2*(pos*2^F + 2^(F-1) + off) + dim, biased by 2*dim*2^18 to stay positive
    function automatic logic [NUM_W-1:0] sample_num(
        input logic [INDEX_W-1:0]        pos,
        input logic signed [COORD_W-1:0] off,
        input logic [DIM_W-1:0]          dim
    );
        logic [NUM_W-1:0] t;
        t = {{(NUM_W - INDEX_W - FRAC_BITS){1'b0}}, pos, {FRAC_BITS{1'b0}}};
        t = t + (NUM_W'(1) << (FRAC_BITS - 1)) + NUM_W'(off);
        t = {t[NUM_W-2:0], 1'b0} + NUM_W'(dim) + (NUM_W'(dim) << (SAMPLE_BIAS_SH + 1));
        return t;
    endfunction

    // quotient would reach 2^20 after removing the bias
    function automatic logic [NUM_W-1:0] sat_limit(input logic [DIM_W-1:0] dim);
        return (NUM_W'(dim) << SQ_W) + (NUM_W'(dim) << (SAMPLE_BIAS_SH + 1));
    endfunction

    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic             sat_x;
    logic             sat_y;
    logic             valid_reg;

    assign nx    = sample_num(INDEX_W'(s_col), offset_x, dim_w);
    assign ny    = sample_num(s_row, offset_y, dim_h);
    assign sat_x = nx >= sat_limit(dim_w);
    assign sat_y = ny >= sat_limit(dim_h);

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            m_num_hi[0]       <= sat_x ? '0 : nx[SQ_W+SD_W-1:SQ_W];
            m_num_hi[1]       <= sat_y ? '0 : ny[SQ_W+SD_W-1:SQ_W];
            m_num_lo[0]       <= nx[SQ_W-1:0];
            m_num_lo[1]       <= ny[SQ_W-1:0];
            m_den[0]          <= {dim_w, 1'b0};
            m_den[1]          <= {dim_h, 1'b0};
            m_side.corners    <= s_corners;
            m_side.sat_x      <= sat_x;
            m_side.sat_y      <= sat_y;
        end
    end

endmodule

// File: rtl/core/ttc_solve.sv
`timescale 1ns / 1ps

module ttc_solve (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0][ttc_pkg::SQ_W-1:0]     s_quot,
    input  ttc_pkg::samp_side_t               s_side,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0][ttc_pkg::WD_W-1:0]     m_num_hi,
    output logic [1:0][ttc_pkg::WQ_W-1:0]     m_num_lo,
    output logic [1:0][ttc_pkg::WD_W-1:0]     m_den,
    output ttc_pkg::wflags_t                  m_flags
);
    import ttc_pkg::*;

    localparam int E_W    = COORD_W + 1;
    localparam int RX_W   = PX_W + 1;
    localparam int DP_W   = 2 * E_W;
    localparam int NP_W   = E_W + RX_W;
    localparam int DET_W  = DP_W + 1;
    localparam int N_W    = NP_W + 1;
    localparam int CMP_W  = N_W + 1;
    localparam int WN_W   = 60;
    localparam int LIM_SH = WEIGHT_W - 1 - FRAC_BITS;
    localparam int STAGES = 5;

    localparam logic signed [PX_W-1:0] PX_MAX = PX_W'((1 << (PX_W - 1)) - 1);

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   rdy;

    // edges and point offset
    logic signed [E_W-1:0]   e0u_reg, e0v_reg, e1u_reg, e1v_reg;
    logic signed [RX_W-1:0]  rx_reg, ry_reg;
    // products
    logic signed [DP_W-1:0]  pd0_reg, pd1_reg;
    logic signed [NP_W-1:0]  pn0a_reg, pn0b_reg, pn1a_reg, pn1b_reg;
    // determinant and numerators
    logic signed [DET_W-1:0] det_reg;
    logic signed [N_W-1:0]   n0_reg, n1_reg;
    // sign-normalized
    logic [WD_W-1:0]         adet_reg;
    logic signed [N_W-1:0]   an0_reg, an1_reg;
    logic                    degen_reg;

    logic signed [PX_W-1:0]  px, py;
    logic signed [DET_W-1:0] det_next;
    logic signed [N_W-1:0]   n0_next, n1_next;
    logic                    neg;
    logic signed [CMP_W-1:0] sum_n, adet_cmp, lim8, a_cmp, b_cmp;
    logic [WN_W-1:0]         wn0, wn1;

    always_comb begin
        px = s_side.sat_x ? PX_MAX : $signed(s_quot[0] - PX_W'(1 << SAMPLE_BIAS_SH));
        py = s_side.sat_y ? PX_MAX : $signed(s_quot[1] - PX_W'(1 << SAMPLE_BIAS_SH));
    end

    assign det_next = DET_W'(pd0_reg) - DET_W'(pd1_reg);
    assign n0_next  = N_W'(pn0a_reg) - N_W'(pn0b_reg);
    assign n1_next  = N_W'(pn1a_reg) - N_W'(pn1b_reg);
    assign neg      = det_reg[DET_W-1];

    always_comb begin
        a_cmp    = CMP_W'(an0_reg);
        b_cmp    = CMP_W'(an1_reg);
        sum_n    = a_cmp + b_cmp;
        adet_cmp = $signed(CMP_W'(adet_reg));
        lim8     = $signed(CMP_W'(adet_reg) << LIM_SH);
        wn0      = (WN_W'(an0_reg) << FRAC_BITS) + (WN_W'(adet_reg) << (WEIGHT_W - 1));
        wn1      = (WN_W'(an1_reg) << FRAC_BITS) + (WN_W'(adet_reg) << (WEIGHT_W - 1));
    end

    always_comb begin
        rdy[STAGES] = m_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_valid) begin
            e0u_reg <= E_W'(s_side.corners.au) - E_W'(s_side.corners.cu);
            e0v_reg <= E_W'(s_side.corners.av) - E_W'(s_side.corners.cv);
            e1u_reg <= E_W'(s_side.corners.bu) - E_W'(s_side.corners.cu);
            e1v_reg <= E_W'(s_side.corners.bv) - E_W'(s_side.corners.cv);
            rx_reg  <= RX_W'(px) - RX_W'(s_side.corners.cu);
            ry_reg  <= RX_W'(py) - RX_W'(s_side.corners.cv);
        end
        if (rdy[1] && v_reg[0]) begin
            pd0_reg  <= e0u_reg * e1v_reg;
            pd1_reg  <= e1u_reg * e0v_reg;
            pn0a_reg <= e1v_reg * rx_reg;
            pn0b_reg <= e1u_reg * ry_reg;
            pn1a_reg <= e0u_reg * ry_reg;
            pn1b_reg <= e0v_reg * rx_reg;
        end
        if (rdy[2] && v_reg[1]) begin
            det_reg <= det_next;
            n0_reg  <= n0_next;
            n1_reg  <= n1_next;
        end
        if (rdy[3] && v_reg[2]) begin
            adet_reg  <= neg ? WD_W'(-det_reg) : WD_W'(det_reg);
            an0_reg   <= neg ? -n0_reg : n0_reg;
            an1_reg   <= neg ? -n1_reg : n1_reg;
            degen_reg <= det_reg == '0;
        end
        if (rdy[4] && v_reg[3]) begin
            m_num_hi[0]        <= wn0[WQ_W+WD_W-1:WQ_W];
            m_num_hi[1]        <= wn1[WQ_W+WD_W-1:WQ_W];
            m_num_lo[0]        <= wn0[WQ_W-1:0];
            m_num_lo[1]        <= wn1[WQ_W-1:0];
            m_den[0]           <= adet_reg;
            m_den[1]           <= adet_reg;
            m_flags.degenerate <= degen_reg;
            m_flags.covered    <= !an0_reg[N_W-1] && !an1_reg[N_W-1] && (sum_n <= adet_cmp);
            m_flags.a_max      <= a_cmp >= lim8;
            m_flags.a_min      <= a_cmp < -lim8;
            m_flags.b_max      <= b_cmp >= lim8;
            m_flags.b_min      <= b_cmp < -lim8;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[STAGES-1];

endmodule

// File: rtl/core/texel_triangle_coverage.sv
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | s_valid / s_ready  | s_texel_index, s_vertex_{a,b,c}_{u,v}
// result    | m_valid / m_ready  | m_covered, m_degenerate, m_bary_{a,b,c}
// config    | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle while no stall on m_ready holds the pipeline. The stages, in order: the row/column
// divider, sample set-up, the sample divider, the solve and the weight divider,
// followed by the output register.
// Reset (aresetn, synchronous) empties the pipeline and loads the register defaults.
// A stall on m_ready holds only the stages that are full; empty stages keep filling.

module texel_triangle_coverage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [ttc_pkg::COORD_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ttc_pkg::INDEX_W-1:0]           s_texel_index,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_a_u,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_a_v,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_b_u,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_b_v,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_c_u,
    input  logic signed [ttc_pkg::COORD_W-1:0]    s_vertex_c_v,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_covered,
    output logic                                  m_degenerate,
    output logic signed [ttc_pkg::WEIGHT_W-1:0]   m_bary_a,
    output logic signed [ttc_pkg::WEIGHT_W-1:0]   m_bary_b,
    output logic signed [ttc_pkg::WEIGHT_W-1:0]   m_bary_c
);
    import ttc_pkg::*;

    localparam int WC_W = WEIGHT_W + 2;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = WEIGHT_W'((1 << (WEIGHT_W - 1)) - 1);
    localparam logic signed [WEIGHT_W-1:0] W_MIN = WEIGHT_W'(1 << (WEIGHT_W - 1));

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] r);
        if (r == '0) begin
            return DIM_W'(1);
        end else if (r > DIM_W'(MAX_TEX)) begin
            return DIM_W'(MAX_TEX);
        end
        return r;
    endfunction

    logic [DIM_W-1:0]          width_reg, height_reg;
    logic signed [COORD_W-1:0] offset_x_reg, offset_y_reg;
    logic [DIM_W-1:0]          dim_w, dim_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(1024);
            height_reg   <= DIM_W'(1024);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:    width_reg    <= cfg_wdata[DIM_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_wdata[DIM_W-1:0];
                CFG_OFFSET_X: offset_x_reg <= cfg_wdata;
                CFG_OFFSET_Y: offset_y_reg <= cfg_wdata;
            endcase
        end
    end

    assign dim_w = clamp_dim(width_reg);
    assign dim_h = clamp_dim(height_reg);

    corners_t in_corners;
    assign in_corners.au = s_vertex_a_u;
    assign in_corners.av = s_vertex_a_v;
    assign in_corners.bu = s_vertex_b_u;
    assign in_corners.bv = s_vertex_b_v;
    assign in_corners.cu = s_vertex_c_u;
    assign in_corners.cv = s_vertex_c_v;

    // row and column of the texel
    logic                        d1_valid, d1_ready;
    logic [0:0][INDEX_W-1:0]     d1_row;
    logic [0:0][DIM_W-1:0]       d1_col;
    logic [$bits(corners_t)-1:0] d1_side;

    ttc_div #(
        .Q_W   (INDEX_W),
        .D_W   (DIM_W),
        .LANES (1),
        .SIDE_W($bits(corners_t))
    ) u_index_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_num_hi('0),
        .s_num_lo(s_texel_index),
        .s_den   (dim_w),
        .s_side  (in_corners),
        .m_valid (d1_valid),
        .m_ready (d1_ready),
        .m_quot  (d1_row),
        .m_rem   (d1_col),
        .m_side  (d1_side)
    );

    logic                        sp_valid, sp_ready;
    logic [1:0][SD_W-1:0]        sp_num_hi;
    logic [1:0][SQ_W-1:0]        sp_num_lo;
    logic [1:0][SD_W-1:0]        sp_den;
    samp_side_t                  sp_side;

    ttc_sample u_sample (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (d1_valid),
        .s_ready  (d1_ready),
        .s_row    (d1_row[0]),
        .s_col    (d1_col[0][CELL_W-1:0]),
        .s_corners(corners_t'(d1_side)),
        .dim_w    (dim_w),
        .dim_h    (dim_h),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .m_valid  (sp_valid),
        .m_ready  (sp_ready),
        .m_num_hi (sp_num_hi),
        .m_num_lo (sp_num_lo),
        .m_den    (sp_den),
        .m_side   (sp_side)
    );

    // sample coordinates, both axes side by side
    logic                          d2_valid, d2_ready;
    logic [1:0][SQ_W-1:0]          d2_quot;
    logic [$bits(samp_side_t)-1:0] d2_side;

    ttc_div #(
        .Q_W   (SQ_W),
        .D_W   (SD_W),
        .LANES (2),
        .SIDE_W($bits(samp_side_t))
    ) u_sample_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (sp_valid),
        .s_ready (sp_ready),
        .s_num_hi(sp_num_hi),
        .s_num_lo(sp_num_lo),
        .s_den   (sp_den),
        .s_side  (sp_side),
        .m_valid (d2_valid),
        .m_ready (d2_ready),
        .m_quot  (d2_quot),
        .m_rem   (),
        .m_side  (d2_side)
    );

    logic                  sv_valid, sv_ready;
    logic [1:0][WD_W-1:0]  sv_num_hi;
    logic [1:0][WQ_W-1:0]  sv_num_lo;
    logic [1:0][WD_W-1:0]  sv_den;
    wflags_t               sv_flags;

    ttc_solve u_solve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (d2_valid),
        .s_ready (d2_ready),
        .s_quot  (d2_quot),
        .s_side  (samp_side_t'(d2_side)),
        .m_valid (sv_valid),
        .m_ready (sv_ready),
        .m_num_hi(sv_num_hi),
        .m_num_lo(sv_num_lo),
        .m_den   (sv_den),
        .m_flags (sv_flags)
    );

    // weights a and b, biased by 2^19
    logic                       d3_valid, d3_ready;
    logic [1:0][WQ_W-1:0]       d3_quot;
    logic [$bits(wflags_t)-1:0] d3_side;

    ttc_div #(
        .Q_W   (WQ_W),
        .D_W   (WD_W),
        .LANES (2),
        .SIDE_W($bits(wflags_t))
    ) u_weight_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (sv_valid),
        .s_ready (sv_ready),
        .s_num_hi(sv_num_hi),
        .s_num_lo(sv_num_lo),
        .s_den   (sv_den),
        .s_side  (sv_flags),
        .m_valid (d3_valid),
        .m_ready (d3_ready),
        .m_quot  (d3_quot),
        .m_rem   (),
        .m_side  (d3_side)
    );

    wflags_t                    fl;
    logic signed [WEIGHT_W-1:0] wa, wb, wc;
    logic signed [WC_W-1:0]     wc_full;
    logic                       m_valid_reg;
    logic                       out_ready;

    always_comb begin
        fl = wflags_t'(d3_side);
        priority if (fl.a_max) begin
            wa = W_MAX;
        end else if (fl.a_min) begin
            wa = W_MIN;
        end else begin
            wa = $signed({~d3_quot[0][WQ_W-1], d3_quot[0][WQ_W-2:0]});
        end
        priority if (fl.b_max) begin
            wb = W_MAX;
        end else if (fl.b_min) begin
            wb = W_MIN;
        end else begin
            wb = $signed({~d3_quot[1][WQ_W-1], d3_quot[1][WQ_W-2:0]});
        end
        wc_full = WC_W'(1 << FRAC_BITS) - WC_W'(wa) - WC_W'(wb);
        priority if (wc_full > WC_W'(W_MAX)) begin
            wc = W_MAX;
        end else if (wc_full < WC_W'(W_MIN)) begin
            wc = W_MIN;
        end else begin
            wc = wc_full[WEIGHT_W-1:0];
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign d3_ready  = out_ready;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= d3_valid;
        end
    end

    // zero determinant: drop coverage and weights
    always_ff @(posedge aclk) begin
        if (out_ready && d3_valid) begin
            m_covered    <= fl.covered && !fl.degenerate;
            m_degenerate <= fl.degenerate;
            m_bary_a     <= fl.degenerate ? '0 : wa;
            m_bary_b     <= fl.degenerate ? '0 : wb;
            m_bary_c     <= fl.degenerate ? '0 : wc;
        end
    end

endmodule

// File: bench/texel_triangle_coverage_tb.sv
`timescale 1ns / 1ps

module texel_triangle_coverage_tb;
    import ttc_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0]        idx;
        logic signed [COORD_W-1:0] au, av, bu, bv, cu, cv;
    } tri_item_t;

    typedef struct packed {
        logic                       cov;
        logic                       deg;
        logic signed [WEIGHT_W-1:0] wa;
        logic signed [WEIGHT_W-1:0] wb;
        logic signed [WEIGHT_W-1:0] wc;
    } cover_t;

    typedef struct {
        tri_item_t item;
        bit        fixed;
        cover_t    res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_WIDTH;
    logic [COORD_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [INDEX_W-1:0] s_texel_index = '0;
    logic signed [COORD_W-1:0] s_vertex_a_u = '0, s_vertex_a_v = '0;
    logic signed [COORD_W-1:0] s_vertex_b_u = '0, s_vertex_b_v = '0;
    logic signed [COORD_W-1:0] s_vertex_c_u = '0, s_vertex_c_v = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_covered, m_degenerate;
    logic signed [WEIGHT_W-1:0] m_bary_a, m_bary_b, m_bary_c;

    texel_triangle_coverage DUT (.*);

    always #5 aclk = ~aclk;

    // shadow copy of the configuration registers
    logic [DIM_W-1:0]   tex_w = 13'd1024, tex_h = 13'd1024;
    logic [COORD_W-1:0] off_x = '0, off_y = '0;

    cover_t pending_cover[$];
    int     errors = 0;
    bit     feeding_done = 0;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint eff_dim(logic [DIM_W-1:0] r);
        longint d;
        d = r;
        if (d == 0) d = 1;
        if (d > MAX_TEX) d = MAX_TEX;
        return d;
    endfunction

    function automatic longint sample_pos(longint cellv, longint off, longint dim);
        longint num;
        num = cellv * 65536 + 32768 + off;
        return clampl(fdiv(2 * num + dim, 2 * dim), -(64'sd1 << 20), (64'sd1 << 20) - 1);
    endfunction

    function automatic longint sat_weight(longint n, longint det);
        longint lim, hi, lo;
        lim = det * (64'sd1 << 19);
        hi = (lim + 65535) >>> 16;
        lo = -(lim >>> 16) - 1;
        if (n >= hi) return 524287;
        if (n <= lo) return -524288;
        return fdiv(n * 65536, det);
    endfunction

    function automatic cover_t predict_cover(tri_item_t it);
        cover_t r;
        longint w, h, col, rowv, px, py, e0u, e0v, e1u, e1v, rx, ry, det, n0, n1, wa, wb;
        w = eff_dim(tex_w);
        h = eff_dim(tex_h);
        col = longint'(it.idx) % w;
        rowv = longint'(it.idx) / w;
        px = sample_pos(col, longint'($signed(off_x)), w);
        py = sample_pos(rowv, longint'($signed(off_y)), h);
        e0u = it.au - it.cu;  e0v = it.av - it.cv;
        e1u = it.bu - it.cu;  e1v = it.bv - it.cv;
        rx = px - it.cu;      ry = py - it.cv;
        det = e0u * e1v - e1u * e0v;
        r = '{cov: 0, deg: 1, wa: 0, wb: 0, wc: 0};
        if (det == 0) return r;
        n0 = e1v * rx - e1u * ry;
        n1 = e0u * ry - e0v * rx;
        if (det < 0) begin
            det = -det; n0 = -n0; n1 = -n1;
        end
        wa = sat_weight(n0, det);
        wb = sat_weight(n1, det);
        r.cov = (n0 >= 0 && n1 >= 0 && n0 + n1 <= det);
        r.deg = 0;
        r.wa = WEIGHT_W'(wa);
        r.wb = WEIGHT_W'(wb);
        r.wc = WEIGHT_W'(clampl(65536 - wa - wb, -524288, 524287));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_WIDTH:    tex_w = val[DIM_W-1:0];
            CFG_HEIGHT:   tex_h = val[DIM_W-1:0];
            CFG_OFFSET_X: off_x = val;
            CFG_OFFSET_Y: off_y = val;
        endcase
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (pending_cover.size() != 0) @(posedge aclk);
        wait_cycles(80);
    endtask

    // valid stays high after an item unless the next one waits
    task automatic send_item(tri_item_t it, bit fixed, cover_t want);
        cover_t p;
        int     idle;
        idle = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
        if (idle > 0) begin
            s_valid <= 1'b0;
            wait_cycles(idle);
        end
        s_valid <= 1'b1;
        s_texel_index <= it.idx;
        s_vertex_a_u <= it.au; s_vertex_a_v <= it.av;
        s_vertex_b_u <= it.bu; s_vertex_b_v <= it.bv;
        s_vertex_c_u <= it.cu; s_vertex_c_v <= it.cv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_cover(it);
        if (fixed && p != want) report_mismatch("table row vs predictor", 0, 1);
        pending_cover.push_back(p);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return COORD_W'($urandom);
            1: return COORD_W'($urandom_range(0, 65536 + 16384) - 8192);
            2: return ($urandom_range(0, 1) ? 18'sh1FFFF : -18'sh20000);
            default: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
        endcase
    endfunction

    function automatic tri_item_t rand_item();
        tri_item_t it;
        longint span;
        span = eff_dim(tex_w) * eff_dim(tex_h);
        it.idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom)
                                               : INDEX_W'($urandom_range(0, span - 1));
        it.au = rand_coord(); it.av = rand_coord();
        it.bu = rand_coord(); it.bv = rand_coord();
        it.cu = rand_coord(); it.cv = rand_coord();
        if ($urandom_range(0, 15) == 0) begin
            it.bu = it.au; it.bv = it.av;
        end
        return it;
    endfunction

    // result side: random back-pressure, compare against oldest expectation
    initial begin
        cover_t want;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                wait_cycles($urandom_range(1, 8));
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_cover.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = pending_cover.pop_front();
                    if (m_covered !== want.cov) report_mismatch("covered", m_covered, want.cov);
                    if (m_degenerate !== want.deg)
                        report_mismatch("degenerate", m_degenerate, want.deg);
                    if (m_bary_a !== want.wa) report_mismatch("bary_a", m_bary_a, want.wa);
                    if (m_bary_b !== want.wb) report_mismatch("bary_b", m_bary_b, want.wb);
                    if (m_bary_c !== want.wc) report_mismatch("bary_c", m_bary_c, want.wc);
                end
            end
        end
    end

    localparam cover_t DEG = '{cov: 0, deg: 1, wa: 0, wb: 0, wc: 0};
    localparam logic signed [COORD_W-1:0] ONE = 18'sd65536;
    localparam logic signed [COORD_W-1:0] CMAX = 18'sh1FFFF;
    localparam logic signed [COORD_W-1:0] CMIN = -18'sh20000;

    row_t directed[] = '{
        // all corners equal: zero determinant
        '{'{0, 0, 0, 0, 0, 0, 0}, 1, DEG},
        '{'{24'hFFFFFF, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, DEG},
        // collinear corners; the rows after it are other triangles with no fixed result
        '{'{5, 0, 0, ONE, ONE, CMIN, CMIN}, 1, DEG},
        '{'{0, 0, 0, ONE, 0, 0, ONE}, 0, DEG},
        '{'{1023, 0, 0, ONE, 0, 0, ONE}, 0, DEG},
        '{'{1024 * 1023 + 1023, 0, 0, ONE, 0, 0, ONE}, 0, DEG},
        '{'{1024 * 512 + 100, ONE, 0, 0, ONE, 0, 0}, 0, DEG},
        '{'{24'hFFFFFF, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX}, 0, DEG},
        '{'{24'h800000, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 0, DEG},
        '{'{300, 18'sd1, 18'sd0, 18'sd0, 18'sd1, 18'sd0, 18'sd0}, 0, DEG},
        '{'{1024 * 1024, 0, 0, CMAX, 0, 0, CMAX}, 0, DEG},
        '{'{77, CMIN, CMAX, CMAX, CMIN, 0, 0}, 0, DEG}
    };

    initial begin
        tri_item_t it;
        logic [COORD_W-1:0] wsel[4];
        wait_cycles(7);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_item(directed[i].item, directed[i].fixed, directed[i].res);
        drain_pipe();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: wsel = '{1, 1, 18'sh10000, 18'sh30000};
                1: wsel = '{4096, 4096, 0, 0};
                2: wsel = '{0, 8191, 18'sh20000, 18'sh1FFFF};
                3: wsel = '{7, 5, 18'sh08000, 18'sh38000};
                default: wsel = '{COORD_W'($urandom_range(1, 64)),
                                  COORD_W'($urandom_range(1, 64)),
                                  COORD_W'($urandom_range(0, 131072) - 65536),
                                  COORD_W'($urandom_range(0, 131072) - 65536)};
            endcase
            write_reg(CFG_WIDTH, wsel[0]);
            write_reg(CFG_HEIGHT, wsel[1]);
            write_reg(CFG_OFFSET_X, wsel[2]);
            write_reg(CFG_OFFSET_Y, wsel[3]);
            for (int n = 0; n < 325; n++) begin
                it = rand_item();
                send_item(it, 0, DEG);
                // hold off until everything in flight has come back
                if (n == 100) begin
                    s_valid <= 1'b0;
                    while (pending_cover.size() != 0) @(posedge aclk);
                end
            end
            drain_pipe();
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
